[rtl/section_address_translator_assert.svh]
// assertion macros used by the checker file
`ifndef SECTION_ADDRESS_TRANSLATOR_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATOR_ASSERT_SVH

// property checked on every rising edge outside reset
`define SAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication whose effect is checked in the next cycle, outside reset
`define SAT_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

[rtl/sat_pkg.sv]
`timescale 1ns / 1ps

package sat_pkg;

  // field widths
  localparam int ADDR_W     = 32;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int REQ_W      = 2;
  localparam int MAX_SLOTS  = 16;

  // stream widths
  localparam int S_TDATA_W  = 136;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 32;
  localparam int M_TUSER_W  = 1;

  // input tdata field offsets
  localparam int ADDRESS_LSB  = 0;
  localparam int INDEX_LSB    = 32;
  localparam int VIRT_LSB     = 36;
  localparam int RAW_PTR_LSB  = 68;
  localparam int RAW_SIZE_LSB = 100;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TO_RAW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TO_VIRT = 2'd2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IMAGE_BASE    = 1'b0;
  localparam logic REG_SECTION_COUNT = 1'b1;

endpackage

[rtl/section_address_translator.sv]
`timescale 1ns / 1ps

// channel     | direction | payload
// ------------+-----------+-------------------------------------------------
// s_axis      | in        | tdata: address, entry fields; tuser: kind, relative
// m_axis      | out       | tdata: result_address; tuser: hit
// apb         | in        | image_base at 0x0, section_count at 0x4
//
// a load is written to the table as it is taken; a translation passes a setup state, tests
// one entry per cycle until the count or a zero-length entry (a forward passthrough below
// entry 0 skips the scan), on a hit with a non-zero raw start runs the subtract and add
// states, plus a base add for an absolute reverse one, then loads the result register
// synchronous reset clears the entry valid bits, so the table reads as zero
// a result waits in the output register while the next transfer is taken in;
// a later result is held back until that register has been taken

module section_address_translator #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // address [31:0], entry_index [35:32], entry_virtual_address [67:36],
  // entry_raw_pointer [99:68], entry_raw_size [131:100], zero [135:132]
  input  logic [sat_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // req_type [1:0], relative [2]
  input  logic [sat_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // result_address [31:0]
  output logic [sat_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // hit [0]
  output logic [sat_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sat_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sat_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sat_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  // slots above the index field range can never be loaded and read as zero
  localparam int DEPTH = (MAX_SECTIONS < sat_pkg::MAX_SLOTS) ? MAX_SECTIONS
                                                              : sat_pkg::MAX_SLOTS;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int AW    = sat_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_SUB, S_ADD, S_BASE, S_DONE
  } state_t;

  state_t state;

  logic [AW-1:0]                  image_base;
  logic [sat_pkg::COUNT_W-1:0]    section_count;

  logic [AW-1:0] sec_virt  [DEPTH];
  logic [AW-1:0] sec_raw   [DEPTH];
  logic [AW-1:0] sec_len   [DEPTH];
  logic [DEPTH-1:0] sec_valid;

  logic            reverse;
  logic            rel;
  logic [AW-1:0]   acc;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] lim;
  logic [AW-1:0]   sel_start;
  logic [AW-1:0]   sel_target;
  logic            res_hit;

  // input field views
  logic [sat_pkg::REQ_W-1:0]   in_req;
  logic                        in_rel;
  logic [AW-1:0]               in_addr;
  logic [sat_pkg::INDEX_W-1:0] in_index;
  logic [AW-1:0]               in_virt;
  logic [AW-1:0]               in_raw;
  logic [AW-1:0]               in_size;
  logic                        in_xfer;
  logic                        load_en;

  assign in_req   = s_axis_tuser[1:0];
  assign in_rel   = s_axis_tuser[2];
  assign in_addr  = s_axis_tdata[sat_pkg::ADDRESS_LSB  +: AW];
  assign in_index = s_axis_tdata[sat_pkg::INDEX_LSB    +: sat_pkg::INDEX_W];
  assign in_virt  = s_axis_tdata[sat_pkg::VIRT_LSB     +: AW];
  assign in_raw   = s_axis_tdata[sat_pkg::RAW_PTR_LSB  +: AW];
  assign in_size  = s_axis_tdata[sat_pkg::RAW_SIZE_LSB +: AW];

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_en       = in_xfer && (in_req == sat_pkg::REQ_LOAD) &&
                         ({1'b0, in_index} < (sat_pkg::INDEX_W + 1)'(DEPTH));

  // configuration registers
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base    <= '0;
      section_count <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        sat_pkg::REG_IMAGE_BASE:    image_base    <= pwdata;
        sat_pkg::REG_SECTION_COUNT: section_count <= pwdata[sat_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sat_pkg::REG_IMAGE_BASE:    prdata = image_base;
      sat_pkg::REG_SECTION_COUNT:
        prdata = {{(sat_pkg::CFG_DATA_W - sat_pkg::COUNT_W){1'b0}}, section_count};
      default:                    prdata = '0;
    endcase
  end

  // section table, valid bits cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_valid <= '0;
    end else if (load_en) begin
      sec_valid[in_index[IDXW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      sec_virt[in_index[IDXW-1:0]] <= in_virt;
      sec_raw[in_index[IDXW-1:0]]  <= in_raw;
      sec_len[in_index[IDXW-1:0]]  <= in_size;
    end
  end

  // entry under test and entry 0 raw start
  logic [IDXW-1:0] idx;
  logic [AW-1:0]   e_virt, e_raw, e_len, e_start, raw0;

  assign idx    = cnt[IDXW-1:0];
  assign e_virt = sec_valid[idx] ? sec_virt[idx] : '0;
  assign e_raw  = sec_valid[idx] ? sec_raw[idx]  : '0;
  assign e_len  = sec_valid[idx] ? sec_len[idx]  : '0;
  assign e_start = reverse ? e_raw : e_virt;
  assign raw0   = sec_valid[0] ? sec_raw[0] : '0;

  // shared adder, operands chosen by the sequencer
  logic [AW-1:0] op_a, op_b, sum;
  logic          op_sub;

  always_comb begin
    op_a   = acc;
    op_b   = image_base;
    op_sub = 1'b0;
    case (state)
      S_PREP: begin
        op_b   = image_base;
        op_sub = 1'b1;
      end
      S_SCAN: begin
        op_a = e_start;
        op_b = e_len;
      end
      S_SUB: begin
        op_b   = sel_start;
        op_sub = 1'b1;
      end
      S_ADD:  op_b = sel_target;
      S_BASE: op_b = image_base;
      default: ;
    endcase
  end

  assign sum = op_a + (op_sub ? ~op_b : op_b) + {{(AW-1){1'b0}}, op_sub};

  logic [AW-1:0] addr_adj;
  assign addr_adj = (!reverse && !rel) ? sum : acc;

  // limit of the scan for this request
  logic [CNTW-1:0] lim_next;
  assign lim_next = (section_count > sat_pkg::COUNT_W'(DEPTH)) ? CNTW'(DEPTH)
                                                              : section_count[CNTW-1:0];

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            reverse <= (in_req == sat_pkg::REQ_TO_VIRT);
            rel     <= in_rel;
            acc     <= in_addr;
            lim     <= lim_next;
            cnt     <= '0;
            case (in_req)
              sat_pkg::REQ_TO_RAW, sat_pkg::REQ_TO_VIRT: state <= S_PREP;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PREP: begin
          acc <= addr_adj;
          if (!reverse && (addr_adj < raw0)) begin
            res_hit <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ((cnt == lim) || (e_len == '0)) begin
            acc     <= '0;
            res_hit <= 1'b0;
            state   <= S_DONE;
          end else if ((acc >= e_start) && (acc < sum)) begin
            res_hit    <= 1'b1;
            sel_start  <= e_start;
            sel_target <= reverse ? e_virt : e_raw;
            // zero raw start returns the address as it stands
            state      <= (e_raw == '0) ? S_DONE : S_SUB;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_SUB: begin
          acc   <= sum;
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= sum;
          state <= (reverse && !rel) ? S_BASE : S_DONE;
        end
        S_BASE: begin
          acc   <= sum;
          state <= S_DONE;
        end
        S_DONE: begin
          // a result taken this cycle frees the register for the next one
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= acc;
            m_axis_tuser  <= res_hit;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sat_checker.sv]
`timescale 1ns / 1ps
`include "section_address_translator_assert.svh"

module sat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sat_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sat_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sat_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  logic s_xfer;
  logic s_translate;
  logic s_load;

  assign s_xfer      = s_axis_tvalid && s_axis_tready;
  assign s_translate = s_xfer && ((s_axis_tuser[1:0] == sat_pkg::REQ_TO_RAW) ||
                                  (s_axis_tuser[1:0] == sat_pkg::REQ_TO_VIRT));
  assign s_load      = s_xfer && (s_axis_tuser[1:0] == sat_pkg::REQ_LOAD);

  // a stalled result holds its payload
  `SAT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a translation takes the block out of idle, so ready is low once it is taken
  `SAT_ASSERT_NEXT(a_busy_after_translate, s_translate, !s_axis_tready, "ready stayed high after a translate transfer")

  // a load completes in the cycle it is taken
  `SAT_ASSERT_NEXT(a_ready_after_load, s_load, s_axis_tready, "ready dropped after a load transfer")

  // no result appears in the cycle after a transfer in
  `SAT_ASSERT_NEXT(a_no_early_result, s_xfer, !$rose(m_axis_tvalid), "result appeared too soon after a transfer")

endmodule

bind section_address_translator sat_checker u_sat_checker (.*);

[verif/tb_section_address_translator.sv]
`timescale 1ns / 1ps

module tb_section_address_translator;

  // request kind the block leaves unused
  localparam logic [sat_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [sat_pkg::CFG_ADDR_W-1:0] ADDR_IMAGE_BASE =
    {sat_pkg::REG_IMAGE_BASE, 2'b00};
  localparam logic [sat_pkg::CFG_ADDR_W-1:0] ADDR_SECTION_COUNT =
    {sat_pkg::REG_SECTION_COUNT, 2'b00};
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 230;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [sat_pkg::REQ_W-1:0]   kind;
    logic                        rel;
    logic [sat_pkg::ADDR_W-1:0]  address;
    logic [sat_pkg::INDEX_W-1:0] slot;
    logic [sat_pkg::ADDR_W-1:0]  virt;
    logic [sat_pkg::ADDR_W-1:0]  raw_ptr;
    logic [sat_pkg::ADDR_W-1:0]  raw_size;
  } section_request_t;

  typedef struct packed {
    logic [sat_pkg::ADDR_W-1:0] address;
    logic                       hit;
  } translation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [sat_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [sat_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sat_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [sat_pkg::M_TUSER_W-1:0]  m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [sat_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [sat_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [sat_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  // predictor copy of the block's registers and section table
  logic [sat_pkg::ADDR_W-1:0]  image_base_copy = '0;
  logic [sat_pkg::COUNT_W-1:0] sect_count = '0;
  logic [sat_pkg::ADDR_W-1:0]  sect_virt [sat_pkg::MAX_SLOTS];
  logic [sat_pkg::ADDR_W-1:0]  sect_raw  [sat_pkg::MAX_SLOTS];
  logic [sat_pkg::ADDR_W-1:0]  sect_len  [sat_pkg::MAX_SLOTS];

  // table as the stimulus sees it, ahead of what the block has taken
  logic [sat_pkg::ADDR_W-1:0]  plan_virt [sat_pkg::MAX_SLOTS];
  logic [sat_pkg::ADDR_W-1:0]  plan_raw  [sat_pkg::MAX_SLOTS];
  logic [sat_pkg::ADDR_W-1:0]  plan_len  [sat_pkg::MAX_SLOTS];

  section_request_t request_queue [$];
  translation_t     expected_translations [$];
  section_request_t offered;

  int send_idle_pct = 14;
  int recv_idle_pct = 50;
  int error_count   = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  logic hold_done   = 1'b0;
  int cycle_count   = 0;

  section_address_translator #(
    .MAX_SECTIONS(sat_pkg::MAX_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // first-match scan of the section table for one translation
  function automatic translation_t translate_address(logic [sat_pkg::REQ_W-1:0] kind,
                                                     logic rel,
                                                     logic [sat_pkg::ADDR_W-1:0] addr_in);
    translation_t r;
    logic [sat_pkg::ADDR_W-1:0] a;
    logic [sat_pkg::ADDR_W-1:0] start;
    logic [sat_pkg::ADDR_W-1:0] stop;
    int i;
    int lim;
    a = addr_in;
    lim = (sect_count > sat_pkg::MAX_SLOTS) ? sat_pkg::MAX_SLOTS : int'(sect_count);
    if (kind == sat_pkg::REQ_TO_RAW && !rel) a = a - image_base_copy;
    r.address = a;
    r.hit = 1'b1;
    // forward passthrough below entry 0 holds whatever the count
    if (kind == sat_pkg::REQ_TO_RAW && a < sect_raw[0]) return r;
    for (i = 0; i < lim; i++) begin
      // zero raw length aborts the scan
      if (sect_len[i] == '0) break;
      start = (kind == sat_pkg::REQ_TO_RAW) ? sect_virt[i] : sect_raw[i];
      stop  = start + sect_len[i];
      if (a >= start && a < stop) begin
        // zero raw start gives the address back as it is
        if (sect_raw[i] == '0) return r;
        if (kind == sat_pkg::REQ_TO_RAW) begin
          r.address = a - start + sect_raw[i];
        end else begin
          r.address = a - start + sect_virt[i];
          if (!rel) r.address = r.address + image_base_copy;
        end
        return r;
      end
    end
    r.address = '0;
    r.hit = 1'b0;
    return r;
  endfunction

  // sender: one transfer offered at a time, prediction taken at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        case (offered.kind)
          sat_pkg::REQ_LOAD: begin
            sect_virt[offered.slot] = offered.virt;
            sect_raw[offered.slot]  = offered.raw_ptr;
            sect_len[offered.slot]  = offered.raw_size;
          end
          sat_pkg::REQ_TO_RAW, sat_pkg::REQ_TO_VIRT:
            expected_translations.push_back(
              translate_address(offered.kind, offered.rel, offered.address));
          default: ;
        endcase
      end
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = request_queue.pop_front();
        s_axis_tdata  <= {4'b0, offered.raw_size, offered.raw_ptr, offered.virt,
                          offered.slot, offered.address};
        s_axis_tuser  <= {offered.rel, offered.kind};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: compare each result transfer, random stalls and one long hold-off
  always @(posedge clk) begin : result_monitor
    translation_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen = results_seen + 1;
        if (expected_translations.size() == 0) begin
          $error("unexpected result: result_address %h hit %b", m_axis_tdata, m_axis_tuser[0]);
          error_count = error_count + 1;
        end else begin
          want = expected_translations.pop_front();
          if (m_axis_tdata !== want.address) begin
            $error("result_address mismatch: expected %h, got %h", want.address, m_axis_tdata);
            error_count = error_count + 1;
          end
          if (m_axis_tuser[0] !== want.hit) begin
            $error("hit mismatch: expected %b, got %b", want.hit, m_axis_tuser[0]);
            error_count = error_count + 1;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // apb write, setup then access
  task automatic reg_write(input logic [sat_pkg::CFG_ADDR_W-1:0] a,
                           input logic [sat_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [sat_pkg::ADDR_W-1:0] base,
                           input logic [sat_pkg::COUNT_W-1:0] count);
    reg_write(ADDR_IMAGE_BASE, base);
    reg_write(ADDR_SECTION_COUNT, sat_pkg::CFG_DATA_W'(count));
    image_base_copy = base;
    sect_count = count;
  endtask

  task automatic push_load(input logic [sat_pkg::INDEX_W-1:0] slot,
                           input logic [sat_pkg::ADDR_W-1:0] va,
                           input logic [sat_pkg::ADDR_W-1:0] rp,
                           input logic [sat_pkg::ADDR_W-1:0] rs);
    section_request_t it;
    it.kind = sat_pkg::REQ_LOAD;
    it.rel = 1'($urandom_range(1));
    it.address = $urandom;
    it.slot = slot;
    it.virt = va;
    it.raw_ptr = rp;
    it.raw_size = rs;
    plan_virt[slot] = va;
    plan_raw[slot]  = rp;
    plan_len[slot]  = rs;
    request_queue.push_back(it);
  endtask

  task automatic push_request(input logic [sat_pkg::REQ_W-1:0] kind, input logic rel,
                              input logic [sat_pkg::ADDR_W-1:0] a);
    section_request_t it;
    it.kind = kind;
    it.rel = rel;
    it.address = a;
    it.slot = sat_pkg::INDEX_W'($urandom);
    it.virt = $urandom;
    it.raw_ptr = $urandom;
    it.raw_size = $urandom;
    request_queue.push_back(it);
  endtask

  // wait for every transfer taken and every result back, then let the scan finish
  task automatic settle();
    while (request_queue.size() != 0 || s_axis_tvalid || expected_translations.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a plausible image: ascending sections with the odd zero size, zero raw start or random entry
  task automatic push_layout();
    logic [sat_pkg::ADDR_W-1:0] va;
    logic [sat_pkg::ADDR_W-1:0] rp;
    logic [sat_pkg::ADDR_W-1:0] size;
    int i;
    va = 32'h1000 * $urandom_range(1, 4);
    rp = 32'h200 * $urandom_range(1, 4);
    for (i = 0; i < sat_pkg::MAX_SLOTS; i++) begin
      size = $urandom_range(32'h3000, 1);
      case ($urandom_range(19))
        0: push_load(sat_pkg::INDEX_W'(i), va, rp, '0);
        1: push_load(sat_pkg::INDEX_W'(i), va, '0, size);
        2: push_load(sat_pkg::INDEX_W'(i), $urandom, $urandom, $urandom);
        default: push_load(sat_pkg::INDEX_W'(i), va, rp, size);
      endcase
      va = va + ((size + 32'hfff) & ~32'hfff) + 32'h1000 * $urandom_range(1);
      rp = rp + ((size + 32'h1ff) & ~32'h1ff);
    end
  endtask

  // mostly lookups aimed at section edges and interiors, plus reloads and noise
  task automatic random_phase(input int target);
    int counted;
    int pick;
    int j;
    logic [sat_pkg::ADDR_W-1:0] base;
    logic [sat_pkg::ADDR_W-1:0] len;
    logic [sat_pkg::ADDR_W-1:0] a;
    logic [sat_pkg::REQ_W-1:0]  k;
    logic                       rel;
    push_layout();
    counted = sat_pkg::MAX_SLOTS;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        push_request(REQ_UNUSED, 1'($urandom_range(1)), $urandom);
      end else if (pick < 12) begin
        counted++;
        if (pick < 8)
          push_load(sat_pkg::INDEX_W'($urandom), $urandom, $urandom, $urandom);
        else
          push_load(sat_pkg::INDEX_W'($urandom), $urandom_range(32'hffff),
                    $urandom_range(32'hffff), $urandom_range(32'h3000));
      end else begin
        counted++;
        k = $urandom_range(1) ? sat_pkg::REQ_TO_RAW : sat_pkg::REQ_TO_VIRT;
        rel = 1'($urandom_range(1));
        j = $urandom_range(sat_pkg::MAX_SLOTS - 1);
        base = (k == sat_pkg::REQ_TO_RAW) ? plan_virt[j] : plan_raw[j];
        len = plan_len[j];
        case ($urandom_range(9))
          0: a = base;
          1: a = base + len - 1;
          2: a = base + len;
          3: a = base - 1;
          4: a = $urandom_range(plan_raw[0]);
          5, 6: a = $urandom;
          default: a = base + ((len == '0) ? '0 : $urandom_range(len - 1));
        endcase
        if (k == sat_pkg::REQ_TO_RAW && !rel) a = a + image_base_copy;
        push_request(k, rel, a);
      end
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < sat_pkg::MAX_SLOTS; i++) begin
      sect_virt[i] = '0;
      sect_raw[i]  = '0;
      sect_len[i]  = '0;
      plan_virt[i] = '0;
      plan_raw[i]  = '0;
      plan_len[i]  = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, edge entries, passthrough, zero count
    configure(32'h0040_0000, 5'd4);
    push_request(sat_pkg::REQ_TO_RAW, 1'b1, 32'h1010);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b0, 32'h410);
    push_load(4'd0, 32'h1000, 32'h400, 32'h1000);
    push_load(4'd1, 32'h2000, 32'h0, 32'h800);
    push_load(4'd2, 32'hffff_ff00, 32'hffff_ff00, 32'h200);
    push_load(4'd3, 32'h3000, 32'h1400, 32'h0);
    push_load(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_request(sat_pkg::REQ_TO_RAW, 1'b0, 32'h0040_0200);
    push_request(sat_pkg::REQ_TO_RAW, 1'b1, 32'h1010);
    push_request(sat_pkg::REQ_TO_RAW, 1'b0, 32'h0040_2010);
    push_request(sat_pkg::REQ_TO_RAW, 1'b1, 32'hffff_ff10);
    push_request(sat_pkg::REQ_TO_RAW, 1'b0, 32'h0);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b1, 32'h410);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b0, 32'h410);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b0, 32'h10);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b1, 32'hffff_ffff);
    push_request(REQ_UNUSED, 1'b1, 32'hffff_ffff);
    settle();
    configure(32'hffff_ffff, 5'd0);
    push_request(sat_pkg::REQ_TO_RAW, 1'b1, 32'h100);
    push_request(sat_pkg::REQ_TO_RAW, 1'b1, 32'h1010);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b0, 32'h410);
    push_request(sat_pkg::REQ_TO_VIRT, 1'b0, 32'h0);
    settle();

    // sender mostly busy, receiver stalling half the time
    configure($urandom & 32'hffff_f000,
              sat_pkg::COUNT_W'($urandom_range(sat_pkg::MAX_SLOTS, 1)));
    random_phase(PHASE_ITEMS);
    settle();

    // the other way round, count above the table depth
    send_idle_pct = 50;
    recv_idle_pct = 14;
    configure(32'hffff_ffff, 5'd31);
    random_phase(PHASE_ITEMS);
    settle();

    // back to back, full table, no base
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'h0, 5'd16);
    random_phase(PHASE_ITEMS);
    settle();

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
